// ===== rtl/core/pidaw_pkg.sv =====
package pidaw_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int ACC_WIDTH      = 40;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam int ERR_WIDTH  = DATA_WIDTH + 1;
  localparam int KG_WIDTH   = GAIN_WIDTH + 1;
  localparam int PROD_WIDTH = ERR_WIDTH + KG_WIDTH;
  localparam int EXT_WIDTH  = ACC_WIDTH + 4;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_MIN    = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_MAX    = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_REVERSE    = 3'd5;

  localparam logic [GAIN_WIDTH-1:0] GAIN_PROP_RST  = 16'd256;
  localparam logic [GAIN_WIDTH-1:0] GAIN_INTEG_RST = 16'd0;
  localparam logic [GAIN_WIDTH-1:0] GAIN_DERIV_RST = 16'd0;
  localparam logic [DATA_WIDTH-1:0] OUT_MIN_RST    = 16'd0;
  localparam logic [DATA_WIDTH-1:0] OUT_MAX_RST    = 16'd255;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] gain_prop;
    logic [GAIN_WIDTH-1:0] gain_integ;
    logic [GAIN_WIDTH-1:0] gain_deriv;
    logic [DATA_WIDTH-1:0] out_min;
    logic [DATA_WIDTH-1:0] out_max;
    logic                  reverse;
  } cfg_t;

  typedef struct packed {
    logic                  mode;
    logic [DATA_WIDTH-1:0] measurement;
    logic [DATA_WIDTH-1:0] setpoint;
    logic [DATA_WIDTH-1:0] manual_output;
  } item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] drive;
    logic                  clamped_high;
    logic                  clamped_low;
  } result_t;

  function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [EXT_WIDTH-1:0] v);
    logic [EXT_WIDTH-ACC_WIDTH:0] upper;
    upper = v[EXT_WIDTH-1:ACC_WIDTH-1];
    if ((&upper) || (~|upper)) begin
      sat_acc = v[ACC_WIDTH-1:0];
    end else if (v[EXT_WIDTH-1]) begin
      sat_acc = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  endfunction

  function automatic logic [EXT_WIDTH-1:0] ext_prod(input logic [PROD_WIDTH-1:0] p);
    ext_prod = {{(EXT_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
  endfunction

  function automatic logic [EXT_WIDTH-1:0] ext_acc(input logic [ACC_WIDTH-1:0] a);
    ext_acc = {{(EXT_WIDTH-ACC_WIDTH){a[ACC_WIDTH-1]}}, a};
  endfunction

  function automatic logic [EXT_WIDTH-1:0] ext_q(input logic [DATA_WIDTH-1:0] d);
    ext_q = {{(EXT_WIDTH-DATA_WIDTH-GAIN_FRAC_BITS){d[DATA_WIDTH-1]}}, d,
             {GAIN_FRAC_BITS{1'b0}}};
  endfunction

  function automatic logic [ERR_WIDTH-1:0] ext_data(input logic [DATA_WIDTH-1:0] d);
    ext_data = {d[DATA_WIDTH-1], d};
  endfunction

  function automatic logic [KG_WIDTH-1:0] sel_gain(input logic [GAIN_WIDTH-1:0] g,
                                                   input logic rev);
    logic [KG_WIDTH-1:0] pos;
    pos = {1'b0, g};
    sel_gain = rev ? (~pos + 1'b1) : pos;
  endfunction

endpackage

// ===== rtl/core/pidaw_if.sv =====
interface pidaw_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] measurement;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] setpoint;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] manual_output;

  modport source(output valid, output mode, output measurement, output setpoint,
                 output manual_output, input ready);
  modport sink(input valid, input mode, input measurement, input setpoint,
               input manual_output, output ready);
endinterface

interface pidaw_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] drive;
  logic                                    clamped_high;
  logic                                    clamped_low;

  modport source(output valid, output drive, output clamped_high, output clamped_low,
                 input ready);
  modport sink(input valid, input drive, input clamped_high, input clamped_low,
               output ready);
endinterface

// ===== rtl/core/pidaw_cfg_regs.sv =====
module pidaw_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  output pidaw_pkg::cfg_t                        cfg
);

  pidaw_pkg::cfg_t cfg_r;
  pidaw_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pidaw_pkg::REG_GAIN_PROP:  cfg_nxt.gain_prop  = cfg_wdata[pidaw_pkg::GAIN_WIDTH-1:0];
        pidaw_pkg::REG_GAIN_INTEG: cfg_nxt.gain_integ = cfg_wdata[pidaw_pkg::GAIN_WIDTH-1:0];
        pidaw_pkg::REG_GAIN_DERIV: cfg_nxt.gain_deriv = cfg_wdata[pidaw_pkg::GAIN_WIDTH-1:0];
        pidaw_pkg::REG_OUT_MIN:    cfg_nxt.out_min    = cfg_wdata[pidaw_pkg::DATA_WIDTH-1:0];
        pidaw_pkg::REG_OUT_MAX:    cfg_nxt.out_max    = cfg_wdata[pidaw_pkg::DATA_WIDTH-1:0];
        pidaw_pkg::REG_REVERSE:    cfg_nxt.reverse    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop  <= pidaw_pkg::GAIN_PROP_RST;
      cfg_r.gain_integ <= pidaw_pkg::GAIN_INTEG_RST;
      cfg_r.gain_deriv <= pidaw_pkg::GAIN_DERIV_RST;
      cfg_r.out_min    <= pidaw_pkg::OUT_MIN_RST;
      cfg_r.out_max    <= pidaw_pkg::OUT_MAX_RST;
      cfg_r.reverse    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pidaw_step.sv =====
module pidaw_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  pidaw_pkg::item_t   item,
  input  pidaw_pkg::cfg_t    cfg,
  output pidaw_pkg::result_t res
);

  logic [pidaw_pkg::ACC_WIDTH-1:0]  integ_r;
  logic [pidaw_pkg::ACC_WIDTH-1:0]  integ_nxt;
  logic [pidaw_pkg::DATA_WIDTH-1:0] prev_meas_r;

  logic signed [pidaw_pkg::ERR_WIDTH-1:0]  err;
  logic signed [pidaw_pkg::ERR_WIDTH-1:0]  dmeas;
  logic signed [pidaw_pkg::KG_WIDTH-1:0]   kp;
  logic signed [pidaw_pkg::KG_WIDTH-1:0]   ki;
  logic signed [pidaw_pkg::KG_WIDTH-1:0]   kd;
  logic signed [pidaw_pkg::PROD_WIDTH-1:0] p_prod;
  logic signed [pidaw_pkg::PROD_WIDTH-1:0] i_prod;
  logic signed [pidaw_pkg::PROD_WIDTH-1:0] d_prod;

  logic signed [pidaw_pkg::EXT_WIDTH-1:0] integ_ext;
  logic signed [pidaw_pkg::EXT_WIDTH-1:0] val;
  logic signed [pidaw_pkg::EXT_WIDTH-1:0] max_q;
  logic signed [pidaw_pkg::EXT_WIDTH-1:0] min_q;
  logic [pidaw_pkg::ACC_WIDTH-1:0]        integ_run;
  logic [pidaw_pkg::ACC_WIDTH-1:0]        integ_step;

  logic signed [pidaw_pkg::DATA_WIDTH-1:0] man;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] omin;
  logic signed [pidaw_pkg::DATA_WIDTH-1:0] omax;
  logic [pidaw_pkg::DATA_WIDTH-1:0]        man_cl;

  always_comb begin
    err   = $signed(pidaw_pkg::ext_data(item.setpoint))
          - $signed(pidaw_pkg::ext_data(item.measurement));
    dmeas = $signed(pidaw_pkg::ext_data(item.measurement))
          - $signed(pidaw_pkg::ext_data(prev_meas_r));
    kp = $signed(pidaw_pkg::sel_gain(cfg.gain_prop, cfg.reverse));
    ki = $signed(pidaw_pkg::sel_gain(cfg.gain_integ, cfg.reverse));
    kd = $signed(pidaw_pkg::sel_gain(cfg.gain_deriv, cfg.reverse));
    p_prod = kp * err;
    i_prod = ki * err;
    d_prod = kd * dmeas;

    integ_run = pidaw_pkg::sat_acc(pidaw_pkg::ext_acc(integ_r)
                                   + pidaw_pkg::ext_prod(i_prod));
    integ_ext = $signed(pidaw_pkg::ext_acc(integ_run));
    val = $signed(pidaw_pkg::ext_prod(p_prod)) + integ_ext
        - $signed(pidaw_pkg::ext_prod(d_prod));
    max_q = $signed(pidaw_pkg::ext_q(cfg.out_max));
    min_q = $signed(pidaw_pkg::ext_q(cfg.out_min));

    man  = $signed(item.manual_output);
    omin = $signed(cfg.out_min);
    omax = $signed(cfg.out_max);
    if (man > omax) begin
      man_cl = cfg.out_max;
    end else if (man < omin) begin
      man_cl = cfg.out_min;
    end else begin
      man_cl = item.manual_output;
    end

    res.clamped_high = 1'b0;
    res.clamped_low  = 1'b0;
    if (val > max_q) begin
      integ_step       = pidaw_pkg::sat_acc(integ_ext - (val - max_q));
      res.drive        = cfg.out_max;
      res.clamped_high = 1'b1;
    end else if (val < min_q) begin
      integ_step      = pidaw_pkg::sat_acc(integ_ext + (min_q - val));
      res.drive       = cfg.out_min;
      res.clamped_low = 1'b1;
    end else begin
      integ_step = integ_run;
      res.drive  = val[pidaw_pkg::GAIN_FRAC_BITS +: pidaw_pkg::DATA_WIDTH];
    end

    if (item.mode) begin
      integ_nxt        = pidaw_pkg::sat_acc(pidaw_pkg::ext_q(man_cl));
      res.drive        = man_cl;
      res.clamped_high = 1'b0;
      res.clamped_low  = 1'b0;
    end else begin
      integ_nxt = integ_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_meas_r <= '0;
    end else if (adv) begin
      integ_r     <= integ_nxt;
      prev_meas_r <= item.measurement;
    end
  end

endmodule

// ===== rtl/core/pid_antiwindup_step.sv =====
// channel   dir  payload                                   handshake
// in_ch     in   mode, measurement, setpoint, manual_output  valid/ready
// out_ch    out  drive, clamped_high, clamped_low           valid/ready
// cfg_*     in   cfg_index, cfg_wdata                      cfg_we, no wait
//
// The path has two registers: the input register, then one combinational pass of three
// 17x17 multiplies, integral add/saturate and limit compare into the result register.
// One transaction per cycle is sustained while the output is ready; integral and previous
// measurement update as an item moves into the result register. Synchronous active-low reset
// clears state, configuration and valid flags. A stalled output backs up the input stage.
module pid_antiwindup_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pidaw_in_if.sink                             in_ch,
  pidaw_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);

  pidaw_pkg::cfg_t    cfg;
  pidaw_pkg::item_t   item_r;
  pidaw_pkg::result_t res;
  pidaw_pkg::result_t res_r;
  logic               item_valid_r;
  logic               out_valid_r;
  logic               adv;
  logic               in_take;

  assign adv        = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || adv;
  assign in_take    = in_ch.valid && in_ch.ready;

  pidaw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidaw_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (adv) begin
        item_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode          <= in_ch.mode;
      item_r.measurement   <= in_ch.measurement;
      item_r.setpoint      <= in_ch.setpoint;
      item_r.manual_output <= in_ch.manual_output;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive        = $signed(res_r.drive);
  assign out_ch.clamped_high = res_r.clamped_high;
  assign out_ch.clamped_low  = res_r.clamped_low;

endmodule

// ===== tb/pidaw_checker.sv =====
`timescale 1ns / 1ps

module pidaw_checker
  import pidaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  pidaw_in_if                       in_mon,
  pidaw_out_if                      out_mon,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending,
  output int                        checked
);

  localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Q_ONE  = longint'(1) <<< GAIN_FRAC_BITS;

  logic [GAIN_WIDTH-1:0]        gain_p, gain_i, gain_d;
  logic signed [DATA_WIDTH-1:0] lim_lo, lim_hi;
  logic                         dir_rev;
  longint                       integ_acc, prev_meas;
  result_t                      drive_due[$];
  int                           n_bad = 0;
  int                           n_checked = 0;

  function automatic longint clip_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic result_t predict_drive(input logic enter_auto,
                                            input logic signed [DATA_WIDTH-1:0] meas,
                                            input logic signed [DATA_WIDTH-1:0] sp,
                                            input logic signed [DATA_WIDTH-1:0] man);
    longint  m, e, dm, kp, ki, kd, v, top_q, bot_q, lo, hi, d;
    result_t r;
    r = '0;
    m = longint'(meas);
    lo = longint'(lim_lo);
    hi = longint'(lim_hi);
    if (enter_auto) begin
      d = longint'(man);
      if (d > hi) d = hi;
      else if (d < lo) d = lo;
      integ_acc = clip_acc(d * Q_ONE);
    end else begin
      kp = longint'(gain_p);
      ki = longint'(gain_i);
      kd = longint'(gain_d);
      if (dir_rev) begin
        kp = -kp;
        ki = -ki;
        kd = -kd;
      end
      e = longint'(sp);
      e = e - m;
      dm = m - prev_meas;
      top_q = hi * Q_ONE;
      bot_q = lo * Q_ONE;
      integ_acc = clip_acc(integ_acc + ki * e);
      v = kp * e + integ_acc - kd * dm;
      if (v > top_q) begin
        integ_acc = clip_acc(integ_acc - (v - top_q));
        d = hi;
        r.clamped_high = 1'b1;
      end else if (v < bot_q) begin
        integ_acc = clip_acc(integ_acc + (bot_q - v));
        d = lo;
        r.clamped_low = 1'b1;
      end else begin
        d = v >>> GAIN_FRAC_BITS;
      end
    end
    prev_meas = m;
    r.drive = d[DATA_WIDTH-1:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [DATA_WIDTH-1:0] want,
                        input logic [DATA_WIDTH-1:0] got);
    n_bad++;
    if (n_bad <= 40)
      $display("mismatch %0d at %0t ns, result %0d: %s expected %h got %h",
               n_bad, $time, n_checked, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      gain_p = GAIN_PROP_RST;
      gain_i = GAIN_INTEG_RST;
      gain_d = GAIN_DERIV_RST;
      lim_lo = OUT_MIN_RST;
      lim_hi = OUT_MAX_RST;
      dir_rev = 1'b0;
      integ_acc = 0;
      prev_meas = 0;
      drive_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (drive_due.size() == 0) begin
          report("result with nothing outstanding, drive", '0, out_mon.drive);
        end else begin
          want = drive_due.pop_front();
          if (out_mon.drive !== want.drive)
            report("drive", want.drive, out_mon.drive);
          if (out_mon.clamped_high !== want.clamped_high)
            report("clamped_high", DATA_WIDTH'(want.clamped_high),
                   DATA_WIDTH'(out_mon.clamped_high));
          if (out_mon.clamped_low !== want.clamped_low)
            report("clamped_low", DATA_WIDTH'(want.clamped_low),
                   DATA_WIDTH'(out_mon.clamped_low));
        end
        n_checked++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_PROP:  gain_p = cfg_wdata;
          REG_GAIN_INTEG: gain_i = cfg_wdata;
          REG_GAIN_DERIV: gain_d = cfg_wdata;
          REG_OUT_MIN:    lim_lo = cfg_wdata;
          REG_OUT_MAX:    lim_hi = cfg_wdata;
          REG_REVERSE:    dir_rev = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        drive_due.push_back(predict_drive(in_mon.mode, in_mon.measurement,
                                          in_mon.setpoint, in_mon.manual_output));
    end
    errors <= n_bad;
    pending <= drive_due.size();
    checked <= n_checked;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pidaw_pkg::*;

  localparam logic MODE_RUN   = 1'b0;
  localparam logic MODE_ENTER = 1'b1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;
  bit                        calm;
  int                        errors, pending, checked;
  int                        n_settings, n_entries;

  pidaw_in_if  in_ch();
  pidaw_out_if out_ch();

  pid_antiwindup_step u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  pidaw_checker u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 25);
  end

  task automatic send(input logic md, input logic [DATA_WIDTH-1:0] ms,
                      input logic [DATA_WIDTH-1:0] st, input logic [DATA_WIDTH-1:0] mo);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.measurement <= ms;
    in_ch.setpoint <= st;
    in_ch.manual_output <= mo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (md == MODE_ENTER) n_entries++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] p, input logic [15:0] i,
                            input logic [15:0] d, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [15:0] rv);
    logic [CFG_DATA_WIDTH-1:0] vals[6];
    logic [CFG_IDX_WIDTH-1:0]  idx[6];
    vals = '{p, i, d, lo, hi, rv};
    idx = '{REG_GAIN_PROP, REG_GAIN_INTEG, REG_GAIN_DERIV, REG_OUT_MIN, REG_OUT_MAX,
            REG_REVERSE};
    drain();
    repeat (4) @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    if ($urandom_range(1)) begin
      cfg_index <= REG_SPARE_A;
      cfg_wdata <= CFG_DATA_WIDTH'($urandom);
      @(posedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_wdata <= CFG_DATA_WIDTH'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 64));
      1: return 16'($urandom_range(0, 1024));
      2: return 16'($urandom);
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic random_setting();
    logic signed [15:0] a, b, lo, hi;
    logic [15:0]        rv;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(5))
      0: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      1: begin
        lo = a;
        hi = a;
      end
      2: begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    rv = 16'($urandom);
    write_regs(pick_gain(), pick_gain(), pick_gain(), lo, hi, rv);
  endtask

  task automatic run_phase(input int n);
    logic signed [15:0] target, pv;
    int                 roll, span, delta;
    target = 16'($urandom);
    pv = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(199) == 0) drain();
      roll = $urandom_range(99);
      if (roll < 8) begin
        send(MODE_ENTER, pv, target, 16'($urandom));
      end else if (roll < 16) begin
        send(MODE_RUN, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        if (roll < 20) target = 16'($urandom);
        span = 1 << $urandom_range(0, 12);
        delta = (int'(target) - int'(pv)) / 8 + int'($urandom_range(0, 2 * span)) - span;
        pv = 16'(int'(pv) + delta);
        send(MODE_RUN, pv, target, 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    n_settings = 0;
    n_entries = 0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RUN;
    in_ch.measurement = '0;
    in_ch.setpoint = '0;
    in_ch.manual_output = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(MODE_RUN, 16'd0, 16'd0, 16'd0);
    send(MODE_RUN, 16'd0, 16'd100, 16'hFFFF);
    send(MODE_RUN, 16'd0, 16'd300, 16'd0);
    send(MODE_RUN, 16'd0, -16'sd5, 16'd0);
    send(MODE_ENTER, 16'd40, 16'd0, 16'd500);
    send(MODE_ENTER, 16'd40, 16'd0, 16'h8000);
    send(MODE_RUN, 16'h8000, 16'h7FFF, 16'h7FFF);
    send(MODE_RUN, 16'h7FFF, 16'h8000, 16'h8000);

    write_regs(16'h0080, 16'h0001, 16'h0100, 16'h8000, 16'h7FFF, 16'h0000);
    send(MODE_ENTER, 16'd0, 16'd0, 16'd0);
    send(MODE_RUN, 16'd3, 16'd0, 16'd0);
    send(MODE_RUN, 16'd3, 16'd4, 16'd0);
    send(MODE_RUN, -16'sd7, 16'd0, 16'd0);
    send(MODE_RUN, 16'h7FFF, 16'h8000, 16'd0);
    send(MODE_ENTER, 16'd9, 16'd0, 16'h7FFF);

    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, -16'sd100, 16'hFFFF);
    send(MODE_ENTER, 16'd0, 16'd0, 16'd0);
    send(MODE_RUN, 16'd0, 16'd0, 16'd0);
    send(MODE_RUN, 16'd1, 16'd0, 16'd0);
    send(MODE_RUN, 16'h8000, 16'h7FFF, 16'd0);
    send(MODE_RUN, 16'h7FFF, 16'h8000, 16'd0);
    send(MODE_ENTER, 16'd5, 16'd0, 16'd200);

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      calm = (ph == 3);
      run_phase(150);
      calm = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("checked %0d control samples under %0d register settings", checked, n_settings);
    $display("bumpless entries %0d, mismatches %0d", n_entries, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
